### hw/rtl/mpsm_pkg.sv
// Shared types and constants for the multi-pattern string matcher.
`default_nettype none
package mpsm_pkg;
  localparam logic [1:0] CMD_PAT_LETTER = 2'd0;
  localparam logic [1:0] CMD_PAT_END    = 2'd1;
  localparam logic [1:0] CMD_BUILD      = 2'd2;
  localparam logic [1:0] CMD_TEXT       = 2'd3;

  localparam int SYM_W = 5;
  localparam int CMD_W = 2;
  localparam int ID_W  = 4;
  localparam int OUT_POS_W = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_END,
    ST_BLD_ROOT_RD,
    ST_BLD_ROOT_WR,
    ST_BLD_POP,
    ST_BLD_CH_RD,
    ST_BLD_CH_CHK,
    ST_BLD_F_RD,
    ST_BLD_F_CHK,
    ST_BLD_MASK_RD,
    ST_BLD_MASK_WR,
    ST_TXT_RD,
    ST_TXT_CHK,
    ST_TXT_MASK_RD,
    ST_TXT_SCAN,
    ST_TXT_EMIT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic ins_rd;       // read goto(insert_node, sym)
    logic ins_wr;       // add child or descend
    logic pat_end;      // close pattern
    logic root_rd;      // read goto(0, c)
    logic root_wr;      // push root child
    logic pop;          // pop queue head
    logic ch_rd;        // read goto(cur, c)
    logic ch_chk;       // child present: start fail walk
    logic f_rd;         // read goto(f, c)
    logic f_chk;        // evaluate walk step
    logic mask_rd;      // read mask of fail target
    logic mask_wr;      // write merged mask, push child
    logic c_next;       // advance letter counter
    logic c_clr;        // clear letter counter
    logic build_done;   // set built
    logic txt_rd;       // read goto(state, sym)
    logic txt_chk;      // evaluate text step
    logic txt_mask_rd;  // read mask of new state
    logic scan_init;    // load mask for listing
    logic emit;         // result transfer taken
    logic txt_done;     // advance position
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic c_last;       // letter counter at last letter
    logic child_nz;     // read child is nonzero
    logic walk_done;    // fail walk finished
    logic q_empty;      // queue exhausted
    logic have_match;   // pending matches remain
    logic accept_ins;   // pattern letter acceptable
    logic built;
    logic busy;         // clearing pass running
  } dp_sts_t;
endpackage
`default_nettype wire

### hw/rtl/mpsm_if.sv
// Valid/ready channel interfaces for the matcher.
`default_nettype none
interface mpsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] symbol;
  modport source (output valid, output cmd, output symbol, input ready);
  modport sink (input valid, input cmd, input symbol, output ready);
endinterface

interface mpsm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pattern_id;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic        last;
  modport source (output valid, output pattern_id, output start_pos, output end_pos,
                  output last, input ready);
  modport sink (input valid, input pattern_id, input start_pos, input end_pos,
                input last, output ready);
endinterface
`default_nettype wire

### hw/rtl/mpsm_ctrl.sv
// Controller state machine for the matcher.
`default_nettype none
module mpsm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_cmd,
  input  wire logic                 sym_ok,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mpsm_pkg::dp_cmd_t         cmd,
  input  wire mpsm_pkg::dp_sts_t    sts
);
  mpsm_pkg::state_t state_r, state_nxt;
  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mpsm_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpsm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            mpsm_pkg::CMD_PAT_LETTER:
              if (sym_ok && sts.accept_ins) state_nxt = mpsm_pkg::ST_INS_RD;
            mpsm_pkg::CMD_PAT_END:
              if (!sts.built) state_nxt = mpsm_pkg::ST_END;
            mpsm_pkg::CMD_BUILD:
              if (!sts.built) state_nxt = mpsm_pkg::ST_BLD_ROOT_RD;
            default:
              if (sym_ok && sts.built) state_nxt = mpsm_pkg::ST_TXT_RD;
          endcase
        end
      end
      mpsm_pkg::ST_INS_RD:      state_nxt = mpsm_pkg::ST_INS_WR;
      mpsm_pkg::ST_INS_WR:      state_nxt = mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_END:         state_nxt = mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_BLD_ROOT_RD: state_nxt = mpsm_pkg::ST_BLD_ROOT_WR;
      mpsm_pkg::ST_BLD_ROOT_WR:
        state_nxt = sts.c_last ? mpsm_pkg::ST_BLD_POP : mpsm_pkg::ST_BLD_ROOT_RD;
      mpsm_pkg::ST_BLD_POP:
        state_nxt = sts.q_empty ? mpsm_pkg::ST_IDLE : mpsm_pkg::ST_BLD_CH_RD;
      mpsm_pkg::ST_BLD_CH_RD:   state_nxt = mpsm_pkg::ST_BLD_CH_CHK;
      mpsm_pkg::ST_BLD_CH_CHK: begin
        if (sts.child_nz)    state_nxt = mpsm_pkg::ST_BLD_F_RD;
        else if (sts.c_last) state_nxt = mpsm_pkg::ST_BLD_POP;
        else                 state_nxt = mpsm_pkg::ST_BLD_CH_RD;
      end
      mpsm_pkg::ST_BLD_F_RD:    state_nxt = mpsm_pkg::ST_BLD_F_CHK;
      mpsm_pkg::ST_BLD_F_CHK:
        state_nxt = sts.walk_done ? mpsm_pkg::ST_BLD_MASK_RD : mpsm_pkg::ST_BLD_F_RD;
      mpsm_pkg::ST_BLD_MASK_RD: state_nxt = mpsm_pkg::ST_BLD_MASK_WR;
      mpsm_pkg::ST_BLD_MASK_WR:
        state_nxt = sts.c_last ? mpsm_pkg::ST_BLD_POP : mpsm_pkg::ST_BLD_CH_RD;
      mpsm_pkg::ST_TXT_RD:      state_nxt = mpsm_pkg::ST_TXT_CHK;
      mpsm_pkg::ST_TXT_CHK:
        state_nxt = sts.walk_done ? mpsm_pkg::ST_TXT_MASK_RD : mpsm_pkg::ST_TXT_RD;
      mpsm_pkg::ST_TXT_MASK_RD: state_nxt = mpsm_pkg::ST_TXT_SCAN;
      mpsm_pkg::ST_TXT_SCAN:
        state_nxt = sts.have_match ? mpsm_pkg::ST_TXT_EMIT : mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_TXT_EMIT:
        if (out_ready && !sts.have_match) state_nxt = mpsm_pkg::ST_IDLE;
      default:                  state_nxt = mpsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      mpsm_pkg::ST_IDLE: begin
        // hold off input while the memories clear
        in_ready = !sts.busy;
        if (in_xfer && in_cmd == mpsm_pkg::CMD_PAT_END && !sts.built) cmd.pat_end = 1'b1;
        if (in_xfer && in_cmd == mpsm_pkg::CMD_BUILD && !sts.built) cmd.c_clr = 1'b1;
      end
      mpsm_pkg::ST_INS_RD:      cmd.ins_rd = 1'b1;
      mpsm_pkg::ST_INS_WR:      cmd.ins_wr = 1'b1;
      mpsm_pkg::ST_BLD_ROOT_RD: cmd.root_rd = 1'b1;
      mpsm_pkg::ST_BLD_ROOT_WR: begin
        cmd.root_wr = 1'b1;
        cmd.c_next  = 1'b1;
      end
      mpsm_pkg::ST_BLD_POP: begin
        cmd.pop   = 1'b1;
        cmd.c_clr = 1'b1;
        if (sts.q_empty) cmd.build_done = 1'b1;
      end
      mpsm_pkg::ST_BLD_CH_RD:   cmd.ch_rd = 1'b1;
      mpsm_pkg::ST_BLD_CH_CHK: begin
        cmd.ch_chk = 1'b1;
        if (!sts.child_nz) cmd.c_next = 1'b1;
      end
      mpsm_pkg::ST_BLD_F_RD:    cmd.f_rd = 1'b1;
      mpsm_pkg::ST_BLD_F_CHK:   cmd.f_chk = 1'b1;
      mpsm_pkg::ST_BLD_MASK_RD: cmd.mask_rd = 1'b1;
      mpsm_pkg::ST_BLD_MASK_WR: begin
        cmd.mask_wr = 1'b1;
        cmd.c_next  = 1'b1;
      end
      mpsm_pkg::ST_TXT_RD:      cmd.txt_rd = 1'b1;
      mpsm_pkg::ST_TXT_CHK:     cmd.txt_chk = 1'b1;
      mpsm_pkg::ST_TXT_MASK_RD: cmd.txt_mask_rd = 1'b1;
      mpsm_pkg::ST_TXT_SCAN: begin
        cmd.scan_init = 1'b1;
        if (!sts.have_match) cmd.txt_done = 1'b1;
      end
      mpsm_pkg::ST_TXT_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (!sts.have_match) cmd.txt_done = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/mpsm_dp.sv
// Datapath for the matcher: trie memories, BFS queue and match lister.
`default_nettype none
module mpsm_dp #(
  parameter int MAX_STATES   = 512,
  parameter int ALPHABET     = 26,
  parameter int MAX_PATTERNS = 16,
  parameter int POS_BITS     = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_xfer,
  input  wire logic [4:0]           in_symbol,
  input  wire mpsm_pkg::dp_cmd_t    cmd,
  output mpsm_pkg::dp_sts_t         sts,
  output logic                      sym_ok,
  output logic [3:0]                out_pattern_id,
  output logic [15:0]               out_start_pos,
  output logic [15:0]               out_end_pos,
  output logic                      out_last
);
  localparam int SW = $clog2(MAX_STATES);
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int GD = MAX_STATES * ALPHABET;
  localparam int GW = $clog2(GD);
  localparam int PW = $clog2(MAX_PATTERNS + 1);
  localparam int MW = MAX_PATTERNS;
  localparam int LW = $clog2(MAX_STATES + 1);
  localparam int CW = $clog2(MAX_STATES + 1);
  localparam int IW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

  // Memories; clearing pass on goto/fail/mask after reset
  logic [SW-1:0] goto_mem [GD];
  logic [SW-1:0] fail_mem [MAX_STATES];
  logic [MW-1:0] mask_mem [MAX_STATES];
  logic [SW-1:0] queue_mem [MAX_STATES];
  logic [LW-1:0] len_mem [MAX_PATTERNS];

  logic          clr_busy_r;
  logic [GW-1:0] clr_idx_r;

  logic [SW-1:0] goto_q_r, fail_q_r, queue_q_r;
  logic [MW-1:0] mask_q_r;

  logic [CW-1:0] node_cnt_r;
  logic [SW-1:0] ins_node_r;
  logic [PW-1:0] pat_cnt_r;
  logic [SW-1:0] cur_state_r;
  logic [POS_BITS-1:0] pos_r;
  logic          built_r;
  logic [LW-1:0] open_len_r;
  logic          open_ovf_r;

  logic [AW-1:0] sym_r;     // letter being worked on
  logic [AW-1:0] c_r;       // build letter counter
  logic [SW-1:0] bcur_r;    // node being expanded
  logic [SW-1:0] child_r;   // child being linked
  logic [SW-1:0] walk_r;    // fail walk node
  logic [SW-1:0] ftgt_r;    // resolved fail target
  logic [CW-1:0] head_r, tail_r;
  logic [LW-1:0] guard_r;
  logic [MW-1:0] pend_r;    // matches still to list
  logic [MW-1:0] valid_pat; // bits for closed patterns
  logic [MW-1:0] cmask_r;   // child's own mask
  logic [MW-1:0] merged;

  // goto address mux
  logic [SW-1:0] ga_node;
  logic [AW-1:0] ga_sym;
  logic [GW-1:0] g_addr;
  logic          g_we;
  logic [GW-1:0] g_waddr;
  logic [SW-1:0] g_wdata;

  logic [SW-1:0] fa_addr;
  logic [SW-1:0] ma_addr;

  // merge mask: child's own mask OR target mask
  assign merged = cmask_r | mask_q_r;

  assign sym_ok = ({{(32-5){1'b0}}, in_symbol} < ALPHABET);

  always_comb begin
    ga_node = ins_node_r;
    ga_sym  = sym_r;
    if (cmd.root_rd) begin
      ga_node = '0;
      ga_sym  = c_r;
    end else if (cmd.ch_rd) begin
      ga_node = bcur_r;
      ga_sym  = c_r;
    end else if (cmd.f_rd) begin
      ga_node = walk_r;
      ga_sym  = c_r;
    end else if (cmd.txt_rd) begin
      ga_node = walk_r;
      ga_sym  = sym_r;
    end
  end

  assign g_addr = GW'(ga_node * ALPHABET) + GW'(ga_sym);

  always_comb begin
    g_we    = clr_busy_r;
    g_waddr = clr_idx_r;
    g_wdata = '0;
    if (!clr_busy_r && cmd.ins_wr && goto_q_r == '0 && node_cnt_r < CW'(MAX_STATES)) begin
      g_we    = 1'b1;
      g_waddr = GW'(ins_node_r * ALPHABET) + GW'(sym_r);
      g_wdata = SW'(node_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) goto_mem[g_waddr] <= g_wdata;
    goto_q_r <= goto_mem[g_addr];
  end

  // fail link memory: fail(cur) read with the child read, walk node otherwise
  logic          f_we;
  logic [SW-1:0] f_waddr, f_wdata;
  always_comb begin
    f_we    = clr_busy_r && (clr_idx_r < GW'(MAX_STATES));
    f_waddr = clr_idx_r[SW-1:0];
    f_wdata = '0;
    if (!clr_busy_r && cmd.root_wr && goto_q_r != '0) begin
      f_we = 1'b1; f_waddr = goto_q_r; f_wdata = '0;
    end else if (!clr_busy_r && cmd.mask_wr) begin
      f_we = 1'b1; f_waddr = child_r; f_wdata = ftgt_r;
    end
  end
  assign fa_addr = cmd.ch_rd ? bcur_r : walk_r;

  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_waddr] <= f_wdata;
    fail_q_r <= fail_mem[fa_addr];
  end

  // mask memory
  logic          m_we;
  logic [SW-1:0] m_waddr;
  logic [MW-1:0] m_wdata;
  always_comb begin
    m_we    = clr_busy_r && (clr_idx_r < GW'(MAX_STATES));
    m_waddr = clr_idx_r[SW-1:0];
    m_wdata = '0;
    if (!clr_busy_r && cmd.pat_end && !open_ovf_r && open_len_r != '0 &&
        pat_cnt_r < PW'(MAX_PATTERNS)) begin
      m_we    = 1'b1;
      m_waddr = ins_node_r;
      m_wdata = MW'(1) << pat_cnt_r;
    end else if (!clr_busy_r && cmd.mask_wr) begin
      m_we    = 1'b1;
      m_waddr = child_r;
      m_wdata = merged;
    end
  end
  // child mask is read during the walk, target mask just before the write
  assign ma_addr = cmd.mask_rd ? ftgt_r : (cmd.f_rd ? child_r : cur_state_r);

  always_ff @(posedge clk) begin
    if (m_we) mask_mem[m_waddr] <= m_wdata;
    mask_q_r <= mask_mem[ma_addr];
  end

  // queue and lengths
  logic          q_we;
  logic [SW-1:0] q_wdata;
  assign q_we    = ((cmd.root_wr && goto_q_r != '0) || cmd.mask_wr) &&
                   tail_r < CW'(MAX_STATES);
  assign q_wdata = cmd.root_wr ? goto_q_r : child_r;

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[tail_r[SW-1:0]] <= q_wdata;
    // forward a push to the head slot
    if (q_we && tail_r[SW-1:0] == head_r[SW-1:0]) queue_q_r <= q_wdata;
    else queue_q_r <= queue_mem[head_r[SW-1:0]];
    if (cmd.pat_end && !open_ovf_r && open_len_r != '0 && pat_cnt_r < PW'(MAX_PATTERNS))
      len_mem[pat_cnt_r[IW-1:0]] <= open_len_r;
  end

  // walk evaluation
  logic walk_stop;
  assign walk_stop = (walk_r == '0) || (goto_q_r != '0) || (guard_r >= LW'(MAX_STATES));

  // match listing: lowest pending bit
  logic [IW-1:0] pick;
  logic [MW-1:0] pend_nxt;
  always_comb begin
    pick = '0;
    for (int j = MAX_PATTERNS - 1; j >= 0; j--)
      if (pend_r[j]) pick = IW'(j);
    pend_nxt = pend_r & ~(MW'(1) << pick);
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERNS; j++)
      valid_pat[j] = (PW'(j) < pat_cnt_r);
  end

  logic [IW-1:0] pick_init, pick_next;
  logic [MW-1:0] init_pend;
  always_comb begin
    init_pend = mask_q_r & valid_pat;
    pick_init = '0;
    pick_next = '0;
    for (int j = MAX_PATTERNS - 1; j >= 0; j--) begin
      if (init_pend[j]) pick_init = IW'(j);
      if (pend_nxt[j])  pick_next = IW'(j);
    end
  end

  logic [LW-1:0] len_q_r;
  always_ff @(posedge clk) len_q_r <= len_mem[cmd.scan_init || cmd.emit ?
                                              (cmd.scan_init ? pick_init : pick_next) : pick];

  assign out_pattern_id = 4'(pick);
  assign out_end_pos    = 16'(pos_r);
  assign out_start_pos  = 16'(pos_r + POS_BITS'(1) - POS_BITS'(len_q_r));
  assign out_last       = (pend_nxt == '0);

  assign sts.c_last     = (c_r == AW'(ALPHABET - 1));
  assign sts.child_nz   = (goto_q_r != '0);
  assign sts.walk_done  = walk_stop;
  assign sts.q_empty    = (head_r >= tail_r);
  assign sts.have_match = cmd.emit ? (pend_nxt != '0) :
                          (cmd.scan_init ? (init_pend != '0) : (pend_r != '0));
  assign sts.accept_ins = !built_r && !clr_busy_r && pat_cnt_r < PW'(MAX_PATTERNS) && !open_ovf_r;
  assign sts.built      = built_r;
  assign sts.busy       = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      node_cnt_r  <= CW'(1);
      ins_node_r  <= '0;
      pat_cnt_r   <= '0;
      cur_state_r <= '0;
      pos_r       <= '0;
      built_r     <= 1'b0;
      open_len_r  <= '0;
      open_ovf_r  <= 1'b0;
      c_r         <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      pend_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + GW'(1);
        if (clr_idx_r == GW'(GD - 1)) clr_busy_r <= 1'b0;
      end
      if (in_xfer) sym_r <= in_symbol[AW-1:0];
      if (cmd.ins_wr) begin
        if (goto_q_r != '0) begin
          ins_node_r <= goto_q_r;
          open_len_r <= open_len_r + LW'(1);
        end else if (node_cnt_r < CW'(MAX_STATES)) begin
          ins_node_r <= SW'(node_cnt_r);
          node_cnt_r <= node_cnt_r + CW'(1);
          open_len_r <= open_len_r + LW'(1);
        end else begin
          open_ovf_r <= 1'b1;
        end
      end
      if (cmd.pat_end) begin
        if (!open_ovf_r && open_len_r != '0 && pat_cnt_r < PW'(MAX_PATTERNS))
          pat_cnt_r <= pat_cnt_r + PW'(1);
        if (pat_cnt_r < PW'(MAX_PATTERNS)) begin
          ins_node_r <= '0;
          open_len_r <= '0;
          open_ovf_r <= 1'b0;
        end
      end
      if (cmd.c_clr) c_r <= '0;
      else if (cmd.c_next) c_r <= c_r + AW'(1);
      if (cmd.root_wr && goto_q_r != '0 && tail_r < CW'(MAX_STATES))
        tail_r <= tail_r + CW'(1);
      if (cmd.pop && !sts.q_empty) begin
        bcur_r <= queue_q_r;
        head_r <= head_r + CW'(1);
      end
      if (cmd.build_done) begin
        built_r    <= 1'b1;
        ins_node_r <= '0;
        open_len_r <= '0;
        open_ovf_r <= 1'b0;
      end
      // fail walk for a new child: start at fail(cur)
      if (cmd.ch_chk && goto_q_r != '0) begin
        child_r <= goto_q_r;
        walk_r  <= fail_q_r;
        guard_r <= '0;
      end
      if (cmd.f_chk) begin
        if (walk_stop) begin
          ftgt_r <= goto_q_r;
          cmask_r <= mask_q_r;
        end else begin
          walk_r  <= fail_q_r;
          guard_r <= guard_r + LW'(1);
        end
      end
      if (cmd.mask_wr && tail_r < CW'(MAX_STATES))
        tail_r <= tail_r + CW'(1);
      // text step walk
      if (in_xfer) begin
        walk_r  <= cur_state_r;
        guard_r <= '0;
      end
      if (cmd.txt_chk) begin
        if (walk_stop) cur_state_r <= goto_q_r;
        else begin
          walk_r  <= fail_q_r;
          guard_r <= guard_r + LW'(1);
        end
      end
      if (cmd.scan_init) pend_r <= init_pend;
      if (cmd.emit) pend_r <= pend_nxt;
      if (cmd.txt_done) pos_r <= pos_r + POS_BITS'(1);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/multi_pattern_string_matcher.sv
// Top level of the multi-pattern string matcher.
// Aho-Corasick matcher: pattern letters (cmd 0) and end items (cmd 1) build a trie, cmd 2
// builds failure links breadth-first, and text letters (cmd 3) each report one transfer per
// pattern ending there, lowest index first, with last set on the final one. After reset a
// clearing pass runs through all MAX_STATES*ALPHABET goto entries and the fail and mask
// memories; input items wait until it ends. A pattern letter reads the goto memory, then
// adds a child or descends; a text letter reads the goto and failure memories once per step
// along its failure chain, then reads the mask, then transfers its matches one at a time.
// The build scans each letter of each queued node and walks the failure chain per child.
`default_nettype none
module multi_pattern_string_matcher #(
  parameter int MAX_STATES   = 512,
  parameter int ALPHABET     = 26,
  parameter int MAX_PATTERNS = 16,
  parameter int POS_BITS     = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mpsm_in_if.sink    in_ch,
  mpsm_out_if.source out_ch
);
  mpsm_pkg::dp_cmd_t cmd;
  mpsm_pkg::dp_sts_t sts;
  logic sym_ok;

  mpsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_cmd(in_ch.cmd), .sym_ok(sym_ok),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  mpsm_dp #(
    .MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET),
    .MAX_PATTERNS(MAX_PATTERNS), .POS_BITS(POS_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_xfer(in_ch.valid && in_ch.ready), .in_symbol(in_ch.symbol),
    .cmd(cmd), .sts(sts), .sym_ok(sym_ok),
    .out_pattern_id(out_ch.pattern_id), .out_start_pos(out_ch.start_pos),
    .out_end_pos(out_ch.end_pos), .out_last(out_ch.last)
  );
endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the multi-pattern string matcher, with its own match predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTATES = 512;
  localparam int NSYM = 26;
  localparam int NPATS = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [4:0] SYM_A = 5'd0;
  localparam logic [4:0] SYM_B = 5'd1;
  localparam logic [4:0] SYM_Z = 5'd25;
  localparam logic [4:0] SYM_BAD = 5'd31;

  typedef struct packed {
    logic [3:0]  pattern_id;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic        last;
  } match_t;

  typedef struct {
    logic [1:0] cmd;
    logic [4:0] sym;
    bit         fill;     // run the random pattern phase at this row
    bit         typed;    // expectation typed in below
    bit         has_res;
    match_t     res;
  } row_t;

  logic clk;
  logic rst_n;
  mpsm_in_if  in_ch ();
  mpsm_out_if out_ch ();

  multi_pattern_string_matcher dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  bit [8:0]  trie_child [0:NSTATES*NSYM-1];
  bit [8:0]  fail_to [0:NSTATES-1];
  bit [15:0] node_mask [0:NSTATES-1];
  bit [8:0]  pat_len [0:NPATS-1];
  int        n_nodes, ins_node, n_pats, cur_state, open_len;
  bit        open_ovf, is_built;
  bit [15:0] text_pos;

  match_t pending_matches [$];
  int     errors;
  int     cycles;
  bit     tx_burst, rx_burst;

  bit [4:0] short_pats [0:NPATS-1][0:3];
  int       short_lens [0:NPATS-1];
  int       n_short;

  function automatic int next_state(int node, int c);
    int g;
    g = 0;
    while (node != 0 && trie_child[node*NSYM+c] == 0 && g < NSTATES) begin
      node = fail_to[node];
      g++;
    end
    return trie_child[node*NSYM+c];
  endfunction

  function automatic void build_links();
    int bfs [$];
    int cur, ch, f;
    for (int c = 0; c < NSYM; c++) begin
      ch = trie_child[c];
      if (ch != 0) begin
        fail_to[ch] = 0;
        bfs.push_back(ch);
      end
    end
    while (bfs.size() != 0) begin
      cur = bfs.pop_front();
      for (int c = 0; c < NSYM; c++) begin
        ch = trie_child[cur*NSYM+c];
        if (ch != 0) begin
          f = next_state(fail_to[cur], c);
          fail_to[ch] = f;
          node_mask[ch] |= node_mask[f];
          bfs.push_back(ch);
        end
      end
    end
    is_built = 1'b1;
    ins_node = 0;
    open_len = 0;
    open_ovf = 1'b0;
  endfunction

  // Advance the predictor by one item and queue the matches it reports.
  function automatic void predict_matches(logic [1:0] cmd, logic [4:0] sym);
    int ch, first;
    match_t m;
    if (cmd == mpsm_pkg::CMD_BUILD) begin
      if (!is_built) build_links();
    end else if (cmd == mpsm_pkg::CMD_PAT_END) begin
      if (!is_built && n_pats < NPATS) begin
        if (!open_ovf && open_len != 0) begin
          node_mask[ins_node] = 16'(1) << n_pats;
          pat_len[n_pats] = 9'(open_len);
          n_pats++;
        end
        ins_node = 0;
        open_len = 0;
        open_ovf = 1'b0;
      end
    end else if (sym < NSYM) begin
      if (cmd == mpsm_pkg::CMD_PAT_LETTER) begin
        if (!is_built && n_pats < NPATS && !open_ovf) begin
          ch = trie_child[ins_node*NSYM+sym];
          if (ch == 0 && n_nodes >= NSTATES) begin
            open_ovf = 1'b1;
          end else begin
            if (ch == 0) begin
              ch = n_nodes++;
              trie_child[ins_node*NSYM+sym] = 9'(ch);
            end
            ins_node = ch;
            open_len++;
          end
        end
      end else if (is_built) begin
        cur_state = next_state(cur_state, sym);
        first = pending_matches.size();
        for (int j = 0; j < n_pats; j++) begin
          if (node_mask[cur_state][j]) begin
            m.pattern_id = 4'(j);
            m.start_pos = text_pos + 16'd1 - 16'(pat_len[j]);
            m.end_pos = text_pos;
            m.last = 1'b0;
            pending_matches.push_back(m);
          end
        end
        if (pending_matches.size() > first)
          pending_matches[pending_matches.size()-1].last = 1'b1;
        text_pos++;
      end
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic send_item(logic [1:0] cmd, logic [4:0] sym);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.symbol <= sym;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_matches(cmd, sym);
  endtask

  task automatic send_pattern(bit [4:0] letters [0:3], int len, bit close);
    for (int k = 0; k < len; k++) send_item(mpsm_pkg::CMD_PAT_LETTER, letters[k]);
    if (close) send_item(mpsm_pkg::CMD_PAT_END, SYM_A);
  endtask

  // Short patterns over c..f, one long pattern over u..y, then repeats.
  task automatic random_patterns();
    bit [4:0] p [0:3];
    int len, pick;
    for (int i = 0; i < 9; i++) begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++) p[k] = 5'($urandom_range(2, 5));
      short_pats[n_short] = p;
      short_lens[n_short] = len;
      n_short++;
      send_pattern(p, len, 1'b1);
    end
    send_item(mpsm_pkg::CMD_PAT_LETTER, 5'd24);
    for (int k = 0; k < 20; k++)
      send_item(mpsm_pkg::CMD_PAT_LETTER, 5'($urandom_range(20, 24)));
    send_item(mpsm_pkg::CMD_PAT_END, SYM_A);
    pick = $urandom_range(0, n_short - 1);
    send_pattern(short_pats[pick], short_lens[pick], 1'b1);
    if ($urandom_range(0, 1) == 1) begin
      // fill the last slot, then extra items are dropped
      send_pattern(short_pats[0], short_lens[0], 1'b1);
      send_item(mpsm_pkg::CMD_PAT_LETTER, SYM_B);
      send_item(mpsm_pkg::CMD_PAT_END, SYM_A);
    end else begin
      // leave a pattern open for the next end item
      pick = $urandom_range(0, n_short - 1);
      send_pattern(short_pats[pick], short_lens[pick], 1'b0);
    end
  endtask

  row_t directed [0:24] = '{
    '{mpsm_pkg::CMD_TEXT,       SYM_A,   0, 1, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_BAD, 0, 1, 0, '0},
    '{mpsm_pkg::CMD_PAT_END,    SYM_A,   0, 1, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_END,    SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_B,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_END,    SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_Z,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_END,    SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_B,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_B,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_END,    SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_B,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_PAT_END,    SYM_A,   1, 0, 0, '0},
    '{mpsm_pkg::CMD_BUILD,      SYM_A,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_TEXT,       SYM_A,   0, 1, 1, '{4'd0, 16'd0, 16'd0, 1'b1}},
    '{mpsm_pkg::CMD_TEXT,       SYM_BAD, 0, 1, 0, '0},
    '{mpsm_pkg::CMD_TEXT,       SYM_B,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_TEXT,       SYM_Z,   0, 0, 0, '0},
    '{mpsm_pkg::CMD_BUILD,      SYM_A,   0, 1, 0, '0},
    '{mpsm_pkg::CMD_PAT_LETTER, SYM_A,   0, 1, 0, '0},
    '{mpsm_pkg::CMD_TEXT,       SYM_A,   0, 0, 0, '0}
  };

  // Result side: stall at random and check each transfer against the oldest expectation.
  initial begin
    int stall, seen;
    match_t want;
    out_ch.ready = 1'b0;
    seen = 0;
    @(posedge clk);
    forever begin
      if (seen % 25 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      seen++;
      if (pending_matches.size() == 0) begin
        report("unexpected result, pattern_id", out_ch.pattern_id, -1);
      end else begin
        want = pending_matches.pop_front();
        if (out_ch.pattern_id !== want.pattern_id)
          report("pattern_id", out_ch.pattern_id, want.pattern_id);
        if (out_ch.start_pos !== want.start_pos)
          report("start_pos", out_ch.start_pos, want.start_pos);
        if (out_ch.end_pos !== want.end_pos)
          report("end_pos", out_ch.end_pos, want.end_pos);
        if (out_ch.last !== want.last)
          report("last", out_ch.last, want.last);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n0, r;
    logic [4:0] sym;
    bit [4:0] text_syms [0:6] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd25};
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = mpsm_pkg::CMD_PAT_LETTER;
    in_ch.symbol = '0;
    errors = 0;
    n_short = 0;
    tx_burst = 1'b0;
    foreach (trie_child[i]) trie_child[i] = '0;
    foreach (fail_to[i]) fail_to[i] = '0;
    foreach (node_mask[i]) node_mask[i] = '0;
    foreach (pat_len[i]) pat_len[i] = '0;
    n_nodes = 1;
    ins_node = 0;
    n_pats = 0;
    cur_state = 0;
    open_len = 0;
    open_ovf = 1'b0;
    is_built = 1'b0;
    text_pos = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].fill) random_patterns();
      n0 = pending_matches.size();
      send_item(directed[i].cmd, directed[i].sym);
      if (directed[i].typed) begin
        while (pending_matches.size() > n0) void'(pending_matches.pop_back());
        if (directed[i].has_res) pending_matches.push_back(directed[i].res);
      end
    end

    for (int i = 0; i < 280; i++) begin
      if (i % 40 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      if (i == 170) begin
        // hold until the result side has drained
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_item(mpsm_pkg::CMD_TEXT, text_syms[$urandom_range(0, 6)]);
      end else if (r < 78) begin
        send_item(mpsm_pkg::CMD_TEXT, 5'($urandom_range(20, 24)));
      end else if (r < 86) begin
        send_item(mpsm_pkg::CMD_TEXT, 5'($urandom_range(26, 31)));
      end else begin
        sym = 5'($urandom_range(0, 31));
        send_item(2'($urandom_range(0, 2)), sym);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_matches.size() != 0) report("results left over", pending_matches.size(), 0);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
